// ----- src/wav_header_parse_downmix_assert.svh -----
// Assertion helpers shared by the parser modules.
// Both expect clk and arst_n to be visible where they are used.
`ifndef WAV_HEADER_PARSE_DOWNMIX_ASSERT_SVH
`define WAV_HEADER_PARSE_DOWNMIX_ASSERT_SVH

// Same-cycle implication.
`define WAVHPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WAVHPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wavhpd_pkg.sv -----
`default_nettype none

package wavhpd_pkg;

	// Number of tag search attempts before giving up
	localparam int SEARCH_LIMIT = 256;
	localparam int ATT_W = (SEARCH_LIMIT > 1) ? $clog2(SEARCH_LIMIT) : 1;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NOT_RIFF = 2'd1;
	localparam logic [1:0] ERR_NO_DATA  = 2'd2;

	// Format codes
	localparam logic [2:0] FMT_UNSUPPORTED = 3'd0;
	localparam logic [2:0] FMT_MONO8       = 3'd1;
	localparam logic [2:0] FMT_MONO16      = 3'd2;
	localparam logic [2:0] FMT_STEREO8     = 3'd3;
	localparam logic [2:0] FMT_STEREO16    = 3'd4;

	// Little-endian tag words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [1:0]         error_code;
		logic [1:0]         warning_flags;
		logic [2:0]         format_code;
		logic [15:0]        audio_format_tag;
		logic [15:0]        channel_count;
		logic [31:0]        sample_rate;
		logic [31:0]        byte_rate;
		logic [15:0]        bits_per_sample;
		logic [31:0]        data_length;
		logic signed [15:0] sample_value;
		logic               sample_last;
	} result_t;

endpackage

`default_nettype wire

// ----- src/wavhpd_in_if.sv -----
`default_nettype none

interface wavhpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

`default_nettype wire

// ----- src/wavhpd_out_if.sv -----
`default_nettype none

interface wavhpd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [1:0]         error_code;
	logic [1:0]         warning_flags;
	logic [2:0]         format_code;
	logic [15:0]        audio_format_tag;
	logic [15:0]        channel_count;
	logic [31:0]        sample_rate;
	logic [31:0]        byte_rate;
	logic [15:0]        bits_per_sample;
	logic [31:0]        data_length;
	logic signed [15:0] sample_value;
	logic               sample_last;

	modport source (
		output valid, output result_kind, output error_code, output warning_flags,
		output format_code, output audio_format_tag, output channel_count,
		output sample_rate, output byte_rate, output bits_per_sample,
		output data_length, output sample_value, output sample_last,
		input ready
	);
	modport sink (
		input valid, input result_kind, input error_code, input warning_flags,
		input format_code, input audio_format_tag, input channel_count,
		input sample_rate, input byte_rate, input bits_per_sample,
		input data_length, input sample_value, input sample_last,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/wavhpd_in_stage.sv -----
`default_nettype none

module wavhpd_in_stage
	import wavhpd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	wavhpd_in_if.sink  bytes,
	input  wire logic  down_ready,
	output logic       go,
	output logic [7:0] byte_s1,
	output logic       start_s1
);

	logic v_s1;

	// Advance the held beat whenever the result side can take its outcome
	assign go          = v_s1 && down_ready;
	assign bytes.ready = !v_s1 || go;

	// Hold valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	// Capture payload on accept
	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1  <= bytes.data_byte;
			start_s1 <= bytes.file_start;
		end
	end

endmodule

`default_nettype wire

// ----- src/wavhpd_core.sv -----
`default_nettype none

`include "wav_header_parse_downmix_assert.svh"

module wavhpd_core
	import wavhpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       go,
	input  wire logic [7:0] byte_s1,
	input  wire logic       start_s1,
	output logic            res_vld,
	output result_t         res
);

	typedef enum logic [3:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_AFMT, PH_CHAN, PH_RATE,
		PH_BRATE, PH_ALIGN, PH_BITS, PH_SEARCH, PH_DSIZE, PH_DATA, PH_IDLE
	} phase_t;

	function automatic logic [7:0] tag_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = 8'h64;
			2'd1:    c = 8'h61;
			2'd2:    c = 8'h74;
			default: c = 8'h61;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] fmt_of(input logic [15:0] ch, input logic [15:0] bits);
		logic [2:0] f;
		f = FMT_UNSUPPORTED;
		if (ch == 16'd1) f = (bits == 16'd8) ? FMT_MONO8 : FMT_MONO16;
		if (ch == 16'd2) f = (bits == 16'd8) ? FMT_STEREO8 : FMT_STEREO16;
		return f;
	endfunction

	// Control state
	phase_t           phase_q, phase_d, ph_e;
	logic [1:0]       idx_q, idx_d, idx_e;
	logic [31:0]      shift_q, shift_d, shift_e;
	logic [1:0]       tpos_q, tpos_d, tpos_e;
	logic [ATT_W-1:0] att_q, att_d, att_e;
	logic [31:0]      rem_q, rem_d, rem_e;
	logic [1:0]       warn_q, warn_d, warn_e;
	logic [2:0]       fsz_q, fsz_d, fsz_e;
	logic             dmx_q;

	// Header and frame payload
	logic [15:0] afmt_q, chan_q, bits_q;
	logic [31:0] rate_q, brate_q;
	logic [7:0]  fb_q [3];
	logic        wr_afmt, wr_chan, wr_rate, wr_brate, wr_bits, wr_fb;
	logic [1:0]  fb_idx;

	logic [31:0] full;
	logic        two_byte, field_last;
	logic [31:0] rem_m1;
	logic [2:0]  fmt;
	logic [16:0] sum8, sum16, sum, adj;

	// Restart overrides the held state for this beat
	always_comb begin
		ph_e    = start_s1 ? PH_RIFF : phase_q;
		idx_e   = start_s1 ? 2'd0 : idx_q;
		shift_e = start_s1 ? 32'd0 : shift_q;
		tpos_e  = start_s1 ? 2'd0 : tpos_q;
		att_e   = start_s1 ? '0 : att_q;
		rem_e   = start_s1 ? 32'd0 : rem_q;
		warn_e  = start_s1 ? 2'd0 : warn_q;
		fsz_e   = start_s1 ? 3'd1 : fsz_q;
	end

	// Field assembly and averaging helpers
	assign full       = shift_e | (32'(byte_s1) << {idx_e, 3'b000});
	assign two_byte   = (ph_e == PH_AFMT) || (ph_e == PH_CHAN) ||
	                    (ph_e == PH_ALIGN) || (ph_e == PH_BITS);
	assign field_last = two_byte ? (idx_e == 2'd1) : (idx_e == 2'd3);
	assign rem_m1     = rem_e - 32'd1;
	assign fmt        = fmt_of(chan_q, bits_q);
	assign sum8       = {{9{fb_q[0][7]}}, fb_q[0]} + {{9{byte_s1[7]}}, byte_s1};
	assign sum16      = {fb_q[1][7], fb_q[1], fb_q[0]} + {byte_s1[7], byte_s1, fb_q[2]};
	assign sum        = (fsz_e == 3'd2) ? sum8 : sum16;
	assign adj        = sum + {16'd0, sum[16]};

	// Step the parser by one byte
	always_comb begin
		phase_d  = ph_e;
		idx_d    = idx_e;
		shift_d  = shift_e;
		tpos_d   = tpos_e;
		att_d    = att_e;
		rem_d    = rem_e;
		warn_d   = warn_e;
		fsz_d    = fsz_e;
		wr_afmt  = 1'b0;
		wr_chan  = 1'b0;
		wr_rate  = 1'b0;
		wr_brate = 1'b0;
		wr_bits  = 1'b0;
		wr_fb    = 1'b0;
		fb_idx   = idx_e;
		res      = '0;
		res_vld  = 1'b0;
		case (ph_e)
			PH_IDLE: begin
			end
			PH_DATA: begin
				rem_d = rem_m1;
				if ((3'(idx_e) + 3'd1) < fsz_e) begin
					wr_fb = (idx_e != 2'd3);
					idx_d = idx_e + 2'd1;
					if (rem_m1 == 32'd0) phase_d = PH_IDLE;
				end else begin
					idx_d           = 2'd0;
					res_vld         = 1'b1;
					res.result_kind = KIND_SAMPLE;
					if (fsz_e == 3'd1) res.sample_value = {8'd0, byte_s1};
					else res.sample_value = adj[16:1];
					res.sample_last = (rem_m1 < 32'(fsz_e));
					if (rem_m1 < 32'(fsz_e)) phase_d = PH_IDLE;
				end
			end
			PH_SEARCH: begin
				if (byte_s1 == tag_char(tpos_e)) begin
					if (tpos_e == 2'd3) begin
						tpos_d  = 2'd0;
						phase_d = PH_DSIZE;
						idx_d   = 2'd0;
						shift_d = 32'd0;
					end else begin
						tpos_d = tpos_e + 2'd1;
					end
				end else begin
					tpos_d = 2'd0;
					if (att_e == ATT_W'(SEARCH_LIMIT - 1)) begin
						res_vld           = 1'b1;
						res.result_kind   = KIND_ERROR;
						res.error_code    = ERR_NO_DATA;
						res.warning_flags = warn_e;
						phase_d           = PH_IDLE;
					end else begin
						att_d = att_e + 1'b1;
					end
				end
			end
			default: begin
				shift_d = full;
				if (!field_last) begin
					idx_d = idx_e + 2'd1;
				end else begin
					idx_d    = 2'd0;
					shift_d  = 32'd0;
					wr_afmt  = (ph_e == PH_AFMT);
					wr_chan  = (ph_e == PH_CHAN);
					wr_rate  = (ph_e == PH_RATE);
					wr_brate = (ph_e == PH_BRATE);
					wr_bits  = (ph_e == PH_BITS);
					if (ph_e == PH_WAVE && full != TAG_WAVE) warn_d = warn_e | 2'b01;
					if (ph_e == PH_FMT && full != TAG_FMT) warn_d = warn_e | 2'b10;
					if (ph_e == PH_RIFF && full != TAG_RIFF) begin
						// Not a RIFF file: fatal
						res_vld           = 1'b1;
						res.result_kind   = KIND_ERROR;
						res.error_code    = ERR_NOT_RIFF;
						res.warning_flags = warn_e;
						phase_d           = PH_IDLE;
					end else if (ph_e == PH_DSIZE) begin
						// Data length known: report the header and enter the data unless it is shorter than one frame
						res_vld              = 1'b1;
						res.result_kind      = KIND_HEADER;
						res.warning_flags    = warn_e;
						res.format_code      = fmt;
						res.audio_format_tag = afmt_q;
						res.channel_count    = chan_q;
						res.sample_rate      = rate_q;
						res.byte_rate        = brate_q;
						res.bits_per_sample  = bits_q;
						res.data_length      = full;
						fsz_d = 3'd1;
						if (dmx_q && fmt == FMT_STEREO8) fsz_d = 3'd2;
						if (dmx_q && fmt == FMT_STEREO16) fsz_d = 3'd4;
						rem_d   = full;
						phase_d = (full < 32'(fsz_d)) ? PH_IDLE : PH_DATA;
					end else begin
						phase_d = phase_t'(ph_e + 4'd1);
						if (ph_e == PH_BITS) begin
							tpos_d = 2'd0;
							att_d  = '0;
						end
					end
				end
			end
		endcase
	end

	// Hold control state, advance on each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			idx_q   <= 2'd0;
			shift_q <= 32'd0;
			tpos_q  <= 2'd0;
			att_q   <= '0;
			rem_q   <= 32'd0;
			warn_q  <= 2'd0;
			fsz_q   <= 3'd1;
			dmx_q   <= 1'b0;
		end else begin
			if (cfg_we) dmx_q <= cfg_wdata;
			if (go) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				shift_q <= shift_d;
				tpos_q  <= tpos_d;
				att_q   <= att_d;
				rem_q   <= rem_d;
				warn_q  <= warn_d;
				fsz_q   <= fsz_d;
			end
		end
	end

	// Store header fields and partial frame bytes
	always_ff @(posedge clk) begin
		if (go) begin
			if (wr_afmt) afmt_q <= full[15:0];
			if (wr_chan) chan_q <= full[15:0];
			if (wr_rate) rate_q <= full;
			if (wr_brate) brate_q <= full;
			if (wr_bits) bits_q <= full[15:0];
			if (wr_fb) fb_q[fb_idx] <= byte_s1;
		end
	end

	`WAVHPD_ASSERT_NOW(a_fsz_onehot, 1'b1, $onehot(fsz_q), "frame size not 1, 2 or 4")
	`WAVHPD_ASSERT_NOW(a_idle_quiet, go && phase_q == PH_IDLE && !start_s1, !res_vld,
		"result produced while idle")
	`WAVHPD_ASSERT_NEXT(a_err_idle, go && res_vld && res.result_kind == KIND_ERROR,
		phase_q == PH_IDLE, "parser not idle after error")

endmodule

`default_nettype wire

// ----- src/wavhpd_out_stage.sv -----
`default_nettype none

`include "wav_header_parse_downmix_assert.svh"

module wavhpd_out_stage
	import wavhpd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  din,
	output logic          up_ready,
	wavhpd_out_if.source  results
);

	logic    v_s2;
	result_t res_s2;

	// Free when empty or draining this cycle
	assign up_ready = !v_s2 || results.ready;

	// Hold valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load) begin
			v_s2 <= 1'b1;
		end else if (results.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_s2 <= din;
	end

	// Drive the channel
	assign results.valid            = v_s2;
	assign results.result_kind      = res_s2.result_kind;
	assign results.error_code       = res_s2.error_code;
	assign results.warning_flags    = res_s2.warning_flags;
	assign results.format_code      = res_s2.format_code;
	assign results.audio_format_tag = res_s2.audio_format_tag;
	assign results.channel_count    = res_s2.channel_count;
	assign results.sample_rate      = res_s2.sample_rate;
	assign results.byte_rate        = res_s2.byte_rate;
	assign results.bits_per_sample  = res_s2.bits_per_sample;
	assign results.data_length      = res_s2.data_length;
	assign results.sample_value     = res_s2.sample_value;
	assign results.sample_last      = res_s2.sample_last;

	`WAVHPD_ASSERT_NOW(a_no_overwrite, load, !v_s2 || results.ready,
		"pending result overwritten")

endmodule

`default_nettype wire

// ----- src/wav_header_parse_downmix.sv -----
// Channel   Dir  Beat contents
// bytes     in   data_byte, file_start
// results   out  header / sample / error result fields
// cfg       in   cfg_we, cfg_wdata (downmix enable)
//
// One byte is accepted every cycle while results drain; a byte enters an
// input register and any result it yields moves into the output register.
// The output register stalls the input only while it holds an untaken result.
// arst_n clears the parser to expect a RIFF tag and disables downmix.
`default_nettype none

module wav_header_parse_downmix
	import wavhpd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	wavhpd_in_if.sink     bytes,
	wavhpd_out_if.source  results,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata
);

	logic       go, down_ready, res_vld;
	logic [7:0] byte_s1;
	logic       start_s1;
	result_t    res;

	wavhpd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.down_ready (down_ready),
		.go         (go),
		.byte_s1    (byte_s1),
		.start_s1   (start_s1)
	);

	wavhpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.go        (go),
		.byte_s1   (byte_s1),
		.start_s1  (start_s1),
		.res_vld   (res_vld),
		.res       (res)
	);

	wavhpd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go && res_vld),
		.din      (res),
		.up_ready (down_ready),
		.results  (results)
	);

endmodule

`default_nettype wire

// ----- verif/wav_header_parse_downmix_test.sv -----
module wav_header_parse_downmix_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wavhpd_pkg::*;

	localparam int CYCLE_LIMIT      = 400_000;
	localparam int ITEM_TARGET      = 1400;
	localparam int MIN_RANDOM_FILES = 4;

	// "data" as it appears on the wire, first character in the low byte
	localparam logic [31:0] DATA_TAG_LE = 32'h6174_6164;
	localparam logic [7:0]  CH_D = DATA_TAG_LE[7:0];
	localparam logic [7:0]  CH_A = DATA_TAG_LE[15:8];
	localparam logic [7:0]  CH_T = DATA_TAG_LE[23:16];

	typedef enum logic [3:0] {
		PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_TAG, PH_FMT_SIZE,
		PH_AUDIO_FMT, PH_CHANNELS, PH_RATE, PH_BYTE_RATE, PH_ALIGN, PH_BITS,
		PH_SEARCH, PH_DATA_SIZE, PH_DATA, PH_IDLE
	} parse_phase_e;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [31:0] riff_tag;
		logic [31:0] riff_size;
		logic [31:0] wave_tag;
		logic [31:0] fmt_tag;
		logic [31:0] fmt_size;
		logic [15:0] audio_fmt;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] data_len;
	} wav_spec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	wavhpd_in_if  in_bus();
	wavhpd_out_if out_bus();

	wav_header_parse_downmix u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (in_bus),
		.results   (out_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Parser mirror
	logic         downmix_cfg;
	parse_phase_e phase;
	logic [1:0]   field_pos;
	logic [31:0]  field_acc;
	logic [1:0]   tag_pos;
	int           search_fails;
	logic [15:0]  hdr_audio_fmt, hdr_chans, hdr_bits;
	logic [31:0]  hdr_rate, hdr_brate, hdr_dlen;
	logic [31:0]  remaining;
	logic [1:0]   warn_bits;
	logic [7:0]   frame_buf[3];
	logic [31:0]  frame_len;

	result_t pending_results[$];
	byte_q_t empty_q;

	int  mismatches, seen_headers, seen_samples, seen_fatals, used_bytes, sent_bytes;
	int  cycle_count;
	int  burst_left;
	bit  gaps_on;
	rx_mode_e stall_mode;
	int  mode_left;

	function automatic void restart_parser();
		phase = PH_RIFF_TAG;
		field_pos = '0;
		field_acc = '0;
		tag_pos = '0;
		search_fails = 0;
		hdr_audio_fmt = '0;
		hdr_chans = '0;
		hdr_bits = '0;
		hdr_rate = '0;
		hdr_brate = '0;
		hdr_dlen = '0;
		remaining = '0;
		warn_bits = '0;
		foreach (frame_buf[i]) frame_buf[i] = '0;
		frame_len = 1;
	endfunction

	function automatic void emit_fatal(logic [1:0] code);
		result_t r;
		r = '0;
		r.result_kind = KIND_ERROR;
		r.error_code = code;
		r.warning_flags = warn_bits;
		pending_results.push_back(r);
		phase = PH_IDLE;
	endfunction

	// Report the header and latch the frame size for the data that follows
	function automatic void emit_header();
		result_t r;
		logic [2:0] fmt;
		if (hdr_chans == 1) begin
			fmt = (hdr_bits == 8) ? FMT_MONO8 : FMT_MONO16;
		end else if (hdr_chans == 2) begin
			fmt = (hdr_bits == 8) ? FMT_STEREO8 : FMT_STEREO16;
		end else begin
			fmt = FMT_UNSUPPORTED;
		end
		r = '0;
		r.result_kind = KIND_HEADER;
		r.warning_flags = warn_bits;
		r.format_code = fmt;
		r.audio_format_tag = hdr_audio_fmt;
		r.channel_count = hdr_chans;
		r.sample_rate = hdr_rate;
		r.byte_rate = hdr_brate;
		r.bits_per_sample = hdr_bits;
		r.data_length = hdr_dlen;
		pending_results.push_back(r);
		frame_len = 1;
		if (downmix_cfg && fmt == FMT_STEREO8) frame_len = 2;
		if (downmix_cfg && fmt == FMT_STEREO16) frame_len = 4;
		remaining = hdr_dlen;
		field_pos = '0;
		phase = (remaining < frame_len) ? PH_IDLE : PH_DATA;
	endfunction

	// Collect a frame; average stereo pairs toward zero when downmixing
	function automatic void data_step(logic [7:0] b);
		int left, right, avg;
		logic [1:0] pos;
		result_t r;
		pos = field_pos;
		remaining = remaining - 1;
		if (pos + 1 < frame_len) begin
			if (pos < 3) frame_buf[pos] = b;
			field_pos = pos + 1;
			if (remaining == 0) phase = PH_IDLE;
			return;
		end
		field_pos = '0;
		if (frame_len == 2) begin
			left = $signed(frame_buf[0]);
			right = $signed(b);
			avg = (left + right) / 2;
		end else if (frame_len == 4) begin
			left = $signed({frame_buf[1], frame_buf[0]});
			right = $signed({b, frame_buf[2]});
			avg = (left + right) / 2;
		end else begin
			avg = b;
		end
		r = '0;
		r.result_kind = KIND_SAMPLE;
		r.sample_value = avg[15:0];
		r.sample_last = (remaining < frame_len);
		pending_results.push_back(r);
		if (remaining < frame_len) phase = PH_IDLE;
	endfunction

	// A byte that breaks a partial match is consumed, never rescanned
	function automatic void search_step(logic [7:0] b);
		if (b == DATA_TAG_LE[8*tag_pos +: 8]) begin
			if (tag_pos == 3) begin
				tag_pos = '0;
				phase = PH_DATA_SIZE;
				field_pos = '0;
				field_acc = '0;
			end else begin
				tag_pos = tag_pos + 1;
			end
			return;
		end
		tag_pos = '0;
		if (search_fails >= SEARCH_LIMIT - 1) begin
			emit_fatal(ERR_NO_DATA);
		end else begin
			search_fails++;
		end
	endfunction

	// Assemble little-endian header fields and check the tags
	function automatic void field_step(logic [7:0] b);
		logic [31:0] len;
		case (phase)
			PH_AUDIO_FMT, PH_CHANNELS, PH_ALIGN, PH_BITS: len = 2;
			default: len = 4;
		endcase
		field_acc = field_acc | ({24'b0, b} << (8 * field_pos));
		if (field_pos + 1 < len) begin
			field_pos = field_pos + 1;
			return;
		end
		field_pos = '0;
		case (phase)
			PH_RIFF_TAG: begin
				if (field_acc != TAG_RIFF) begin
					emit_fatal(ERR_NOT_RIFF);
					return;
				end
			end
			PH_WAVE_TAG: if (field_acc != TAG_WAVE) warn_bits[0] = 1'b1;
			PH_FMT_TAG: if (field_acc != TAG_FMT) warn_bits[1] = 1'b1;
			PH_AUDIO_FMT: hdr_audio_fmt = field_acc[15:0];
			PH_CHANNELS: hdr_chans = field_acc[15:0];
			PH_RATE: hdr_rate = field_acc;
			PH_BYTE_RATE: hdr_brate = field_acc;
			PH_BITS: hdr_bits = field_acc[15:0];
			PH_DATA_SIZE: hdr_dlen = field_acc;
			default: ;
		endcase
		field_acc = '0;
		if (phase == PH_DATA_SIZE) begin
			emit_header();
			return;
		end
		phase = parse_phase_e'(phase + 1);
		if (phase == PH_SEARCH) begin
			tag_pos = '0;
			search_fails = 0;
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic start);
		if (start) restart_parser();
		if (phase == PH_IDLE) return;
		used_bytes++;
		case (phase)
			PH_DATA: data_step(b);
			PH_SEARCH: search_step(b);
			default: field_step(b);
		endcase
	endfunction

	// Drive one beat at the falling edge, hold until accepted
	task automatic send_byte(input logic [7:0] b, input logic start);
		@(negedge clk);
		in_bus.valid <= 1'b1;
		in_bus.data_byte <= b;
		in_bus.file_start <= start;
		do @(posedge clk); while (in_bus.ready !== 1'b1);
		sent_bytes++;
		parse_byte(b, start);
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				repeat ($urandom_range(1, 6)) begin
					@(negedge clk);
					in_bus.valid <= 1'b0;
				end
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Hold the input until every predicted result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_downmix(input logic en);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(negedge clk);
		cfg_we <= 1'b0;
		downmix_cfg = en;
	endtask

	task automatic send_file(input byte_q_t f, input int count = 1 << 30);
		for (int i = 0; i < count && i < f.size(); i++) send_byte(f[i], i == 0);
	endtask

	task automatic send_noise(input int n, input bit allow_start);
		for (int i = 0; i < n; i++) begin
			send_byte($urandom_range(0, 255), allow_start && $urandom_range(0, 15) == 0);
		end
	endtask

	function automatic void push_le(ref byte_q_t q, input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
	endfunction

	function automatic byte_q_t rand_bytes(int n);
		byte_q_t q;
		repeat (n) q.push_back($urandom_range(0, 255));
		return q;
	endfunction

	function automatic wav_spec_t pcm_spec(int chans, int bits, logic [31:0] dlen);
		wav_spec_t s;
		s.riff_tag = TAG_RIFF;
		s.riff_size = 36 + dlen;
		s.wave_tag = TAG_WAVE;
		s.fmt_tag = TAG_FMT;
		s.fmt_size = 16;
		s.audio_fmt = 1;
		s.chans = chans;
		s.rate = 44100;
		s.brate = 44100 * chans * bits / 8;
		s.align = chans * bits / 8;
		s.bits = bits;
		s.data_len = dlen;
		return s;
	endfunction

	// Lay out a file: RIFF header, fmt fields, junk, data tag, size, payload
	function automatic byte_q_t build_file(wav_spec_t s, byte_q_t junk, byte_q_t payload);
		byte_q_t f;
		push_le(f, s.riff_tag, 4);
		push_le(f, s.riff_size, 4);
		push_le(f, s.wave_tag, 4);
		push_le(f, s.fmt_tag, 4);
		push_le(f, s.fmt_size, 4);
		push_le(f, s.audio_fmt, 2);
		push_le(f, s.chans, 2);
		push_le(f, s.rate, 4);
		push_le(f, s.brate, 4);
		push_le(f, s.align, 2);
		push_le(f, s.bits, 2);
		f = {f, junk};
		push_le(f, DATA_TAG_LE, 4);
		push_le(f, s.data_len, 4);
		f = {f, payload};
		return f;
	endfunction

	task automatic test_mono_basic();
		send_file(build_file(pcm_spec(1, 8, 4), empty_q, {8'h00, 8'hFF, 8'h80, 8'h7F}));
		send_noise(5, 1'b0);
		send_file(build_file(pcm_spec(1, 16, 6), empty_q, rand_bytes(6)));
	endtask

	task automatic test_bad_riff();
		wav_spec_t s;
		s = pcm_spec(1, 8, 2);
		s.riff_tag = 32'h5846_4952;
		send_file(build_file(s, empty_q, rand_bytes(2)));
		s.riff_tag = 32'h4646_4953;
		send_file(build_file(s, empty_q, rand_bytes(2)));
		s.riff_tag = ~TAG_RIFF;
		send_file(build_file(s, empty_q, rand_bytes(2)));
		send_noise(6, 1'b0);
	endtask

	task automatic test_tag_warnings();
		wav_spec_t s;
		s = pcm_spec(1, 8, 2);
		s.wave_tag = 32'h5845_4157;
		send_file(build_file(s, empty_q, rand_bytes(2)));
		s = pcm_spec(2, 8, 2);
		s.fmt_tag = '0;
		send_file(build_file(s, empty_q, rand_bytes(2)));
		s.wave_tag = '1;
		send_file(build_file(s, empty_q, rand_bytes(2)));
	endtask

	task automatic test_data_search();
		send_file(build_file(pcm_spec(1, 8, 2), {CH_D, CH_A, CH_D}, rand_bytes(2)));
		send_file(build_file(pcm_spec(1, 8, 2), {CH_D, CH_D, CH_A, CH_T}, rand_bytes(2)));
		send_file(build_file(pcm_spec(1, 8, 2), {CH_A, CH_D, CH_A, CH_T, CH_T}, rand_bytes(2)));
		// a dangling "dat" swallows the first character of the real tag
		send_file(build_file(pcm_spec(1, 8, 2), {CH_D, CH_A, CH_T}, rand_bytes(2)));
	endtask

	// One attempt short of the limit finds the tag; at the limit it gives up
	task automatic test_search_limit();
		byte_q_t junk;
		logic [7:0] b;
		for (int n = SEARCH_LIMIT - 1; n <= SEARCH_LIMIT; n++) begin
			junk = {};
			repeat (n) begin
				do b = $urandom_range(0, 255); while (b == CH_D);
				junk.push_back(b);
			end
			send_file(build_file(pcm_spec(1, 8, 3), junk, rand_bytes(3)));
		end
	endtask

	task automatic test_downmix_stereo8();
		set_downmix(1'b1);
		send_file(build_file(pcm_spec(2, 8, 15), empty_q,
			{8'h80, 8'h80, 8'h7F, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFF,
			 8'h80, 8'h7F, 8'h81, 8'h80, 8'hFE, 8'hFF, 8'h55}));
	endtask

	task automatic test_downmix_stereo16();
		send_file(build_file(pcm_spec(2, 16, 23), empty_q,
			{8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'h7F,
			 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F,
			 8'h01, 8'h80, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56}));
	endtask

	task automatic test_frame_edges();
		send_file(build_file(pcm_spec(2, 8, 1), empty_q, rand_bytes(3)));
		send_file(build_file(pcm_spec(2, 16, 3), empty_q, rand_bytes(3)));
		send_file(build_file(pcm_spec(2, 8, 2), empty_q, rand_bytes(2)));
		send_file(build_file(pcm_spec(2, 24, 8), empty_q, rand_bytes(8)));
		send_file(build_file(pcm_spec(1, 8, 3), empty_q, rand_bytes(3)));
		send_file(build_file(pcm_spec(3, 8, 2), empty_q, rand_bytes(2)));
		send_file(build_file(pcm_spec(1, 16, 0), empty_q, rand_bytes(2)));
		set_downmix(1'b0);
		send_file(build_file(pcm_spec(2, 16, 4), empty_q, rand_bytes(4)));
	endtask

	task automatic test_field_extremes();
		wav_spec_t s;
		s.riff_tag = TAG_RIFF;
		s.riff_size = '1;
		s.wave_tag = '1;
		s.fmt_tag = '1;
		s.fmt_size = '1;
		s.audio_fmt = '1;
		s.chans = '1;
		s.rate = '1;
		s.brate = '1;
		s.align = '1;
		s.bits = '1;
		s.data_len = '1;
		send_file(build_file(s, empty_q, rand_bytes(6)));
		s = pcm_spec(0, 0, 0);
		s.riff_size = '0;
		s.fmt_size = '0;
		s.audio_fmt = '0;
		s.rate = '0;
		send_file(build_file(s, empty_q, rand_bytes(2)));
	endtask

	// Restart mid-header, mid-tag and mid-data
	task automatic test_restart();
		byte_q_t f;
		f = build_file(pcm_spec(2, 16, 8), empty_q, rand_bytes(8));
		send_file(f, 20);
		send_file(f, 38);
		send_file(build_file(pcm_spec(1, 8, 1000), empty_q, rand_bytes(5)));
		send_file(f);
	endtask

	task automatic test_random_files();
		wav_spec_t s;
		byte_q_t junk, payload, f;
		int files, r, idx;
		files = 0;
		while (sent_bytes < ITEM_TARGET || files < MIN_RANDOM_FILES) begin
			if ($urandom_range(0, 9) == 0) set_downmix($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
			s = pcm_spec(1, 8, 0);
			r = $urandom_range(0, 9);
			s.chans = (r < 4) ? 1 : (r < 8) ? 2 : $urandom_range(0, 65535);
			r = $urandom_range(0, 19);
			s.bits = (r < 9) ? 8 : (r < 18) ? 16 : $urandom_range(0, 65535);
			s.riff_size = $urandom;
			s.fmt_size = $urandom;
			s.rate = $urandom;
			s.brate = $urandom;
			s.align = $urandom_range(0, 65535);
			if ($urandom_range(0, 9) == 0) s.audio_fmt = $urandom_range(0, 65535);
			if ($urandom_range(0, 9) == 0) s.wave_tag = $urandom;
			if ($urandom_range(0, 9) == 0) s.fmt_tag = $urandom;
			junk = {};
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 3))
					0: junk.push_back(CH_D);
					1: junk.push_back(CH_A);
					2: junk.push_back(CH_T);
					default: junk.push_back($urandom_range(0, 255));
				endcase
			end
			if ($urandom_range(0, 9) == 0) begin
				s.data_len = $urandom;
				payload = rand_bytes($urandom_range(0, 16));
			end else begin
				s.data_len = $urandom_range(0, 24);
				payload = rand_bytes(s.data_len + $urandom_range(0, 3));
			end
			f = build_file(s, junk, payload);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_file(f);
			end else if (r < 85) begin
				send_file(f, $urandom_range(1, f.size() - 1));
			end else if (r < 93) begin
				// flip one bit somewhere in the tags and leading fields
				idx = $urandom_range(0, 15);
				f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
				send_file(f);
			end else begin
				send_noise($urandom_range(1, 8), 1'b1);
			end
			files++;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted result beat against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result_kind: expected no result, got 0x%0h", out_bus.result_kind);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.result_kind, out_bus.result_kind);
				check_field("error_code", want.error_code, out_bus.error_code);
				check_field("warning_flags", want.warning_flags, out_bus.warning_flags);
				check_field("format_code", want.format_code, out_bus.format_code);
				check_field("audio_format_tag", want.audio_format_tag,
					out_bus.audio_format_tag);
				check_field("channel_count", want.channel_count, out_bus.channel_count);
				check_field("sample_rate", want.sample_rate, out_bus.sample_rate);
				check_field("byte_rate", want.byte_rate, out_bus.byte_rate);
				check_field("bits_per_sample", want.bits_per_sample,
					out_bus.bits_per_sample);
				check_field("data_length", want.data_length, out_bus.data_length);
				check_field("sample_value", want.sample_value, out_bus.sample_value);
				check_field("sample_last", want.sample_last, out_bus.sample_last);
				case (want.result_kind)
					KIND_HEADER: seen_headers++;
					KIND_SAMPLE: seen_samples++;
					default: seen_fatals++;
				endcase
			end
		end
	end

	// Stall the result side in randomly chosen modes
	always @(negedge clk) begin
		if (mode_left <= 0) begin
			stall_mode = rx_mode_e'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
		end
		mode_left--;
		case (stall_mode)
			RX_OPEN: out_bus.ready <= 1'b1;
			RX_COIN: out_bus.ready <= $urandom_range(0, 1);
			RX_PERIODIC: out_bus.ready <= (mode_left % 3 != 0);
			default: out_bus.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("wav_header_parse_downmix verification failed");
			$finish;
		end
	end

	initial begin
		in_bus.valid = 1'b0;
		in_bus.data_byte = '0;
		in_bus.file_start = 1'b0;
		out_bus.ready = 1'b0;
		downmix_cfg = 1'b0;
		restart_parser();
		gaps_on = 1'b1;
		burst_left = $urandom_range(1, 24);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_mono_basic();
		test_bad_riff();
		test_tag_warnings();
		test_data_search();
		test_search_limit();
		test_downmix_stereo8();
		test_downmix_stereo16();
		test_frame_edges();
		test_field_extremes();
		test_restart();
		test_random_files();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes (%0d parsed): %0d header, %0d sample, %0d fatal results checked",
			sent_bytes, used_bytes, seen_headers, seen_samples, seen_fatals);
		$display("Included tag warnings, search limit, 8/16-bit downmix, partial frames, restarts");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("wav_header_parse_downmix verification clean");
		end else begin
			$display("wav_header_parse_downmix verification failed");
		end
		$finish;
	end

endmodule
